// ===== rtl/bcf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcf_pkg
// Shared types and constants for the biquad cascade filter core.
// ---------------------------------------------------------------------------
package bcf_pkg;

  // Fixed field widths
  localparam int COEF_BITS = 16;  // Q2.14 coefficient word
  localparam int SLOT_BITS = 5;   // coefficient slot address
  localparam int TAPS      = 5;   // b0, b1, b2, a1, a2
  localparam int HIST      = 4;   // x1, x2, y1, y2
  localparam int ADDR_BITS = 3;   // APB byte address
  localparam int DATA_BITS = 32;  // APB data
  localparam int ACT_BITS  = 3;   // active_sections register

  // Transaction kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // Register index (byte address / 4)
  localparam logic [ADDR_BITS-3:0] REG_ACTIVE = '0;

  // Tap position inside a section
  typedef enum logic [2:0] {
    TAP_B0 = 3'd0,
    TAP_B1 = 3'd1,
    TAP_B2 = 3'd2,
    TAP_A1 = 3'd3,
    TAP_A2 = 3'd4
  } tap_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;      // latch sample, clear section counters
    logic coef_wr;    // write coefficient word from the input
    logic coef_rd;    // read next coefficient
    logic hist_rd;    // read history row of current section
    logic mul;        // register one product
    tap_t tap;        // operand select for the product
    logic acc_en;     // accumulate product
    logic acc_first;  // first product of a section
    logic acc_sub;    // subtract (feedback taps)
    logic sec_done;   // round, saturate, write history, next section
    logic out_load;   // load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_sec;   // current section is the last active one
    logic out_busy;   // result register holds an untaken result
  } status_t;

endpackage

// ===== rtl/bcf_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcf_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module bcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bcf_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcf_ctrl
// Sequencer: accepts transactions and steps the shared MAC through five taps
// per section.
// ---------------------------------------------------------------------------
module bcf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             kind,
  output logic             in_ready,
  input  bcf_pkg::status_t status,
  output bcf_pkg::cmd_t    cmd
);

  // Step schedule inside one section
  localparam logic [2:0] STEP_RD_LAST  = 3'd4;  // last coefficient read
  localparam logic [2:0] STEP_MUL_FST  = 3'd1;
  localparam logic [2:0] STEP_MUL_LAST = 3'd5;
  localparam logic [2:0] STEP_ACC_FST  = 3'd2;
  localparam logic [2:0] STEP_ACC_LAST = 3'd6;
  localparam logic [2:0] STEP_SUB_FST  = 3'd5;  // a1 product reaches the acc
  localparam logic [2:0] STEP_WB       = 3'd7;

  bcf_pkg::state_t state, state_next;
  logic [2:0]      step, step_next;

  // State and step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcf_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      bcf_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        step_next = '0;
        if (in_valid) begin
          if (kind == bcf_pkg::KIND_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = bcf_pkg::ST_RUN;
          end
        end
      end
      bcf_pkg::ST_RUN: begin
        cmd.coef_rd   = (step <= STEP_RD_LAST);
        cmd.hist_rd   = (step == '0);
        cmd.mul       = (step >= STEP_MUL_FST) && (step <= STEP_MUL_LAST);
        cmd.tap       = bcf_pkg::tap_t'(step - STEP_MUL_FST);
        cmd.acc_en    = (step >= STEP_ACC_FST) && (step <= STEP_ACC_LAST);
        cmd.acc_first = (step == STEP_ACC_FST);
        cmd.acc_sub   = (step >= STEP_SUB_FST);
        step_next     = step + 3'd1;
        if (step == STEP_WB) begin
          cmd.sec_done = 1'b1;
          step_next    = '0;
          if (status.last_sec) begin
            state_next = bcf_pkg::ST_DONE;
          end
        end
      end
      bcf_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = bcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bcf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bcf_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcf_dpath
// Datapath: coefficient and history RAMs, shared multiplier and accumulator,
// rounding and saturation, result register.
// ---------------------------------------------------------------------------
module bcf_dpath #(
  parameter int SECTIONS       = 4,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bcf_pkg::cmd_t                          cmd,
  output bcf_pkg::status_t                       status,
  input  logic [bcf_pkg::ACT_BITS-1:0]           active_sections,
  input  logic signed [SAMPLE_BITS-1:0]          sample_in,
  input  logic [bcf_pkg::SLOT_BITS-1:0]          coef_slot,
  input  logic signed [bcf_pkg::COEF_BITS-1:0]   coef_word,
  input  logic                                   block_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_BITS-1:0]          sample_out,
  output logic                                   clipped,
  output logic                                   block_last
);

  localparam int SB     = SAMPLE_BITS;
  localparam int CDEPTH = bcf_pkg::TAPS * SECTIONS;
  localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int HW     = bcf_pkg::HIST * SB;
  localparam int PROD_W = bcf_pkg::COEF_BITS + SB;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RND_W  = ((ACC_W > COEF_FRAC_BITS) ? ACC_W : COEF_FRAC_BITS) + 2;
  localparam int CNT_W  = bcf_pkg::ACT_BITS + 2;

  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] SMAX = (RND_W'(1) << (SB - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] SMIN = -SMAX - RND_W'(1);

  // Section control registers
  logic signed [SB-1:0]  x_cur;
  logic                  blk_end;
  logic [SEC_W-1:0]      sec, sec_last;
  logic [CA_W-1:0]       caddr;
  logic                  clip;
  logic [SECTIONS-1:0]   hist_vld;

  // Arithmetic registers
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // RAM data
  logic [bcf_pkg::COEF_BITS-1:0] coef_rdata;
  logic [HW-1:0]                 hist_rdata;
  logic [HW-1:0]                 hist_wdata;
  logic                          slot_ok;

  // Combinational values
  logic signed [SB-1:0]    x1, x2, y1, y2, operand, y_new;
  logic [CNT_W-1:0]        act_ext;
  logic [CNT_W-1:0]        last_cnt;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [RND_W-1:0] rnd, shifted;
  logic                    sat;

  // Coefficient store
  assign slot_ok = (int'(coef_slot) < CDEPTH);

  bcf_ram #(
    .WIDTH (bcf_pkg::COEF_BITS),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cmd.coef_wr && slot_ok),
    .waddr (CA_W'(coef_slot)),
    .wdata (coef_word),
    .re    (cmd.coef_rd),
    .raddr (caddr),
    .rdata (coef_rdata)
  );

  // History store, one row {y2, y1, x2, x1} per section
  bcf_ram #(
    .WIDTH (HW),
    .DEPTH (SECTIONS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (cmd.sec_done),
    .waddr (sec),
    .wdata (hist_wdata),
    .re    (cmd.hist_rd),
    .raddr (sec),
    .rdata (hist_rdata)
  );

  // History operands, zero until the row was first written
  always_comb begin
    x1 = '0;
    x2 = '0;
    y1 = '0;
    y2 = '0;
    if (hist_vld[sec]) begin
      x1 = $signed(hist_rdata[SB-1:0]);
      x2 = $signed(hist_rdata[2*SB-1:SB]);
      y1 = $signed(hist_rdata[3*SB-1:2*SB]);
      y2 = $signed(hist_rdata[4*SB-1:3*SB]);
    end
  end

  // Operand select
  always_comb begin
    case (cmd.tap)
      bcf_pkg::TAP_B0: operand = x_cur;
      bcf_pkg::TAP_B1: operand = x1;
      bcf_pkg::TAP_B2: operand = x2;
      bcf_pkg::TAP_A1: operand = y1;
      bcf_pkg::TAP_A2: operand = y2;
      default:         operand = x_cur;
    endcase
  end

  // Round half up, then saturate to the sample range
  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign rnd      = {{(RND_W - ACC_W){acc[ACC_W-1]}}, acc} + HALF;
  assign shifted  = rnd >>> COEF_FRAC_BITS;

  always_comb begin
    sat   = 1'b0;
    y_new = shifted[SB-1:0];
    if (shifted > SMAX) begin
      sat   = 1'b1;
      y_new = SMAX[SB-1:0];
    end else if (shifted < SMIN) begin
      sat   = 1'b1;
      y_new = SMIN[SB-1:0];
    end
  end

  assign hist_wdata = {y1, y_new, x1, x_cur};

  // Clamp section count to 1..SECTIONS, keep index of last section
  assign act_ext = CNT_W'(active_sections);
  always_comb begin
    if (act_ext == '0) begin
      last_cnt = '0;
    end else if (act_ext > CNT_W'(SECTIONS)) begin
      last_cnt = CNT_W'(SECTIONS - 1);
    end else begin
      last_cnt = act_ext - CNT_W'(1);
    end
  end

  // Multiply and accumulate
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= $signed(coef_rdata) * operand;
    end
    if (cmd.acc_en) begin
      if (cmd.acc_first) begin
        acc <= cmd.acc_sub ? -prod_ext : prod_ext;
      end else begin
        acc <= cmd.acc_sub ? acc - prod_ext : acc + prod_ext;
      end
    end
  end

  // Per-transaction state
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_cur    <= sample_in;
      blk_end  <= block_end;
      sec      <= '0;
      sec_last <= SEC_W'(last_cnt);
      caddr    <= '0;
      clip     <= 1'b0;
    end else begin
      if (cmd.coef_rd) begin
        caddr <= caddr + CA_W'(1);
      end
      if (cmd.sec_done) begin
        x_cur <= y_new;
        clip  <= clip | sat;
        sec   <= sec + SEC_W'(1);
      end
    end
  end

  // History valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
    end else if (cmd.sec_done) begin
      hist_vld[sec] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_out <= x_cur;
      clipped    <= clip;
      block_last <= blk_end;
    end
  end

  assign status.last_sec = (sec == sec_last);
  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== rtl/biquad_cascade_df1_filter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biquad_cascade_df1_filter_core
// Cascade of Direct Form I biquad sections on one shared multiply-accumulate.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): kind 1 writes coef_word into coefficient
//   slot coef_slot (section*5 + b0,b1,b2,a1,a2) and gives no result; a slot
//   beyond the store is dropped. Kind 0 filters sample_in through sections
//   0..N-1, N = active_sections clamped to 1..SECTIONS.
//   Output channel (out_valid/out_ready): one transaction per sample with the
//   filtered sample, a saturation flag and block_end copied to block_last.
//   Timing: a coefficient write is taken in idle and the core stays ready for
//   the next transaction. A sample is filtered section by section: the single
//   MAC reads coefficients and history, works through five taps and writes
//   history back, then the done state loads the result register and the core
//   returns to idle; in_ready is low from acceptance until that return.
//   A finished result sits in an output register; the next transaction is
//   taken while it waits. If the result is still not taken when the next
//   sample finishes, the core holds until out_ready.
//   Reset clears the section history (valid bits, no sweep) and sets
//   active_sections to 1. Coefficients must be written before use.
//   APB: register 0 at byte address 0 is active_sections (3 bits).
// ---------------------------------------------------------------------------
module biquad_cascade_df1_filter_core #(
  parameter int SECTIONS       = 4,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bcf_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [bcf_pkg::DATA_BITS-1:0]        pwdata,
  output logic [bcf_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  input  logic [bcf_pkg::SLOT_BITS-1:0]        coef_slot,
  input  logic signed [bcf_pkg::COEF_BITS-1:0] coef_word,
  input  logic                                 block_end,
  // Output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        sample_out,
  output logic                                 clipped,
  output logic                                 block_last
);

  logic [bcf_pkg::ACT_BITS-1:0]  active_sections;
  logic [bcf_pkg::ADDR_BITS-3:0] reg_idx;
  logic                          reg_wr;
  bcf_pkg::cmd_t                 cmd;
  bcf_pkg::status_t              status;

  // APB register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[bcf_pkg::ADDR_BITS-1:2];
  assign reg_wr  = psel && penable && pwrite && (reg_idx == bcf_pkg::REG_ACTIVE);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sections <= bcf_pkg::ACT_BITS'(1);
    end else if (reg_wr) begin
      active_sections <= pwdata[bcf_pkg::ACT_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == bcf_pkg::REG_ACTIVE) begin
      prdata = bcf_pkg::DATA_BITS'(active_sections);
    end
  end

  // Sequencer
  bcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  bcf_dpath #(
    .SECTIONS       (SECTIONS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .active_sections (active_sections),
    .sample_in       (sample_in),
    .coef_slot       (coef_slot),
    .coef_word       (coef_word),
    .block_end       (block_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample_out      (sample_out),
    .clipped         (clipped),
    .block_last      (block_last)
  );

endmodule

// ===== rtl/bcf_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcf_checker
// Port-level assertions for the biquad cascade core, bound to the top level.
// ---------------------------------------------------------------------------
module bcf_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   kind,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample_out,
  input logic                   clipped,
  input logic                   block_last
);

  // The core is not ready in the cycle after it accepts a sample
  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == bcf_pkg::KIND_SAMPLE) |=> !in_ready)
    else $error("core took a transaction right after a sample");

  // A coefficient write never produces a result
  a_coef_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == bcf_pkg::KIND_COEF && !out_valid) |=> !out_valid)
    else $error("result appeared after a coefficient write");

  // A result never appears right after a sample is accepted
  a_sample_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == bcf_pkg::KIND_SAMPLE && !out_valid) |=> !out_valid)
    else $error("result appeared one cycle after sample acceptance");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(sample_out) && $stable(clipped) && $stable(block_last)))
    else $error("stalled result changed");

endmodule

bind biquad_cascade_df1_filter_core bcf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bcf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .kind       (kind),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out),
  .clipped    (clipped),
  .block_last (block_last)
);
